@@ rtl/eps_pkg.sv @@
// ----------------------------------------------------------------------------
// eps_pkg
// types, constants and helpers shared by the element-wise combiner
// ----------------------------------------------------------------------------
package eps_pkg;

   localparam int NUM_LANES  = 4;
   localparam int MAX_INPUTS = 4;
   localparam int LANE_W     = $clog2(NUM_LANES);
   localparam int COUNT_W    = 3;
   localparam int OP_W       = 2;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int PROD_W     = 32;
   localparam int TOTAL_W    = 34;
   localparam int SAT_W      = 24;

   typedef logic signed [15:0] q88_type;
   typedef logic signed [15:0] weight_type;
   typedef logic signed [TOTAL_W-1:0] total_type;
   typedef logic [LANE_W-1:0] lane_idx_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam q88_type Q88_ONE = 16'sd256;
   localparam q88_type Q88_MAX = 16'sh7fff;
   localparam q88_type Q88_MIN = 16'sh8000;
   localparam weight_type WEIGHT_ONE = 16'sd4096;
   localparam count_type MAX_COUNT = COUNT_W'(MAX_INPUTS);
   localparam count_type COUNT_RESET = 3'd2;

   typedef enum logic [OP_W-1:0] {
      OP_PROD = 2'd0,
      OP_SUM  = 2'd1,
      OP_MAX  = 2'd2
   } op_type;

   // register indexes, byte address is 4 * index
   typedef enum logic [CSR_ADDR_W-3:0] {
      REG_OPERATION = 3'd0,
      REG_COUNT     = 3'd1,
      REG_WEIGHT0   = 3'd2,
      REG_WEIGHT1   = 3'd3,
      REG_WEIGHT2   = 3'd4,
      REG_WEIGHT3   = 3'd5
   } reg_idx_type;

   typedef struct packed {
      op_type                      op;
      count_type                   count;   // already clamped to MAX_INPUTS
      weight_type [NUM_LANES-1:0]  weight;
   } cfg_type;

   typedef struct packed {
      q88_type [NUM_LANES-1:0] elem;
      q88_type                 acc;
      total_type               total;
      logic                    clip;
   } lane_data_type;

   typedef struct packed {
      q88_type val;
      logic    clip;
   } sat_type;

   function automatic sat_type sat_q88(input logic signed [SAT_W-1:0] v);
      sat_type s;
      if (v > SAT_W'(Q88_MAX)) begin
         s.val  = Q88_MAX;
         s.clip = 1'b1;
      end else if (v < SAT_W'(Q88_MIN)) begin
         s.val  = Q88_MIN;
         s.clip = 1'b1;
      end else begin
         s.val  = v[15:0];
         s.clip = 1'b0;
      end
      return s;
   endfunction

endpackage

@@ rtl/eps_ifs.sv @@
// ----------------------------------------------------------------------------
// eps channel interfaces
// valid/ready channels for element requests and combined responses
// ----------------------------------------------------------------------------
interface eps_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] elem0;
   logic signed [15:0] elem1;
   logic signed [15:0] elem2;
   logic signed [15:0] elem3;

   modport source (output valid, elem0, elem1, elem2, elem3, input ready);
   modport sink (input valid, elem0, elem1, elem2, elem3, output ready);
endinterface

interface eps_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] result;
   logic               saturated;

   modport source (output valid, result, saturated, input ready);
   modport sink (input valid, result, saturated, output ready);
endinterface

@@ rtl/eps_csr.sv @@
// ----------------------------------------------------------------------------
// eps_csr
// apb register file: operation, input count and sum weights
// ----------------------------------------------------------------------------
module eps_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [eps_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [eps_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [eps_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output eps_pkg::cfg_type                cfg
);
   import eps_pkg::*;

   logic [OP_W-1:0]             op_ff;
   count_type                   count_ff;
   weight_type [NUM_LANES-1:0]  weight_ff;
   logic                        wr_en;
   reg_idx_type                 idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= OP_W'(OP_SUM);
         count_ff <= COUNT_RESET;
         for (int i = 0; i < NUM_LANES; i++) begin
            weight_ff[i] <= WEIGHT_ONE;
         end
      end else if (wr_en) begin
         unique case (idx)
            REG_OPERATION: op_ff        <= pwdata[OP_W-1:0];
            REG_COUNT:     count_ff     <= pwdata[COUNT_W-1:0];
            REG_WEIGHT0:   weight_ff[0] <= pwdata[15:0];
            REG_WEIGHT1:   weight_ff[1] <= pwdata[15:0];
            REG_WEIGHT2:   weight_ff[2] <= pwdata[15:0];
            REG_WEIGHT3:   weight_ff[3] <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_OPERATION: prdata = CSR_DATA_W'(op_ff);
         REG_COUNT:     prdata = CSR_DATA_W'(count_ff);
         REG_WEIGHT0:   prdata = CSR_DATA_W'(weight_ff[0]);
         REG_WEIGHT1:   prdata = CSR_DATA_W'(weight_ff[1]);
         REG_WEIGHT2:   prdata = CSR_DATA_W'(weight_ff[2]);
         REG_WEIGHT3:   prdata = CSR_DATA_W'(weight_ff[3]);
         default:       prdata = '0;
      endcase
   end

   // counts above the lane limit are clamped
   always_comb begin
      cfg.op     = op_type'(op_ff);
      cfg.count  = (count_ff > MAX_COUNT) ? MAX_COUNT : count_ff;
      cfg.weight = weight_ff;
   end

endmodule

@@ rtl/eps_lane_stage.sv @@
// ----------------------------------------------------------------------------
// eps_lane_stage
// one pipeline stage: folds the element of one lane into the running value
// ----------------------------------------------------------------------------
module eps_lane_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  eps_pkg::lane_idx_type  lane_idx,
   input  eps_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  eps_pkg::lane_data_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output eps_pkg::lane_data_type out_data
);
   import eps_pkg::*;

   logic                      valid_ff;
   lane_data_type             data_ff;
   lane_data_type             data_in;
   q88_type                   elem;
   q88_type                   mul_a;
   logic signed [PROD_W-1:0]  prod;
   logic signed [PROD_W-1:0]  prod_bias;
   sat_type                   prod_sat;
   logic                      active;

   // one shared multiplier: acc * elem for product, weight * elem for sum
   always_comb begin
      elem      = $signed(in_data.elem[lane_idx]);
      mul_a     = (cfg.op == OP_PROD) ? $signed(in_data.acc) : $signed(cfg.weight[lane_idx]);
      prod      = PROD_W'(mul_a) * PROD_W'(elem);
      prod_bias = prod + PROD_W'(128);
      prod_sat  = sat_q88(prod_bias[PROD_W-1:8]);
      active    = COUNT_W'(lane_idx) < cfg.count;

      data_in = in_data;
      if (active) begin
         unique case (cfg.op)
            OP_PROD: begin
               data_in.acc  = prod_sat.val;
               data_in.clip = in_data.clip | prod_sat.clip;
            end
            OP_SUM: data_in.total = $signed(in_data.total) + TOTAL_W'(prod);
            OP_MAX: begin
               if ($signed(in_data.acc) < elem) begin
                  data_in.acc = elem;
               end
            end
            default: ;
         endcase
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ rtl/eps_out_stage.sv @@
// ----------------------------------------------------------------------------
// eps_out_stage
// final rounding of the weighted sum, operation select and response register
// ----------------------------------------------------------------------------
module eps_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  eps_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  eps_pkg::lane_data_type in_data,
   eps_rsp_if.source              rsp
);
   import eps_pkg::*;

   logic                      valid_ff;
   q88_type                   result_ff;
   logic                      saturated_ff;
   q88_type                   result_in;
   logic                      saturated_in;
   logic signed [TOTAL_W:0]   sum_bias;
   sat_type                   sum_sat;

   always_comb begin
      // q.20 down to q8.8, half an lsb added first
      sum_bias = (TOTAL_W+1)'($signed(in_data.total)) + (TOTAL_W+1)'(2048);
      sum_sat  = sat_q88(SAT_W'($signed(sum_bias[TOTAL_W:12])));
      unique case (cfg.op)
         OP_PROD: begin
            result_in    = in_data.acc;
            saturated_in = in_data.clip;
         end
         OP_SUM: begin
            result_in    = sum_sat.val;
            saturated_in = sum_sat.clip;
         end
         OP_MAX: begin
            result_in    = in_data.acc;
            saturated_in = 1'b0;
         end
         default: begin
            result_in    = '0;
            saturated_in = 1'b0;
         end
      endcase
   end

   assign in_ready      = !valid_ff || rsp.ready;
   assign rsp.valid     = valid_ff;
   assign rsp.result    = result_ff;
   assign rsp.saturated = saturated_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         result_ff    <= result_in;
         saturated_ff <= saturated_in;
      end
   end

endmodule

@@ rtl/eltwise_prod_sum_max_unit.sv @@
// ----------------------------------------------------------------------------
// eltwise_prod_sum_max_unit
// element-wise product, weighted sum or maximum of up to four q8.8 tensors
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  req_chan  in         valid/ready      elem0..elem3, signed q8.8
//  rsp_chan  out        valid/ready      result q8.8, saturated flag
//  apb       in         psel/penable     operation, input_count, weight0..3
//
//  one transfer per cycle sustained while the response side is ready; one register per lane stage
//  (each owns a single 16x16 multiplier) plus the rounding/response register
//  synchronous active-high reset empties the pipeline and loads register defaults
//  a stalled response holds its stage; bubbles collapse, so the request side keeps
//  taking transfers while any stage is free
// ----------------------------------------------------------------------------
module eltwise_prod_sum_max_unit (
   input  logic                            clock,
   input  logic                            reset,
   eps_req_if.sink                         req_chan,
   eps_rsp_if.source                       rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [eps_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [eps_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [eps_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import eps_pkg::*;

   cfg_type        cfg;
   lane_data_type  entry_data;

   // stage k hands over to stage k+1; index NUM_LANES is the response stage
   logic           stage_valid [NUM_LANES+1];
   logic           stage_ready [NUM_LANES+1];
   lane_data_type  stage_data  [NUM_LANES+1];

   eps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // starting value of the running result depends on the operation
   always_comb begin
      entry_data.elem[0] = req_chan.elem0;
      entry_data.elem[1] = req_chan.elem1;
      entry_data.elem[2] = req_chan.elem2;
      entry_data.elem[3] = req_chan.elem3;
      entry_data.total   = '0;
      entry_data.clip    = 1'b0;
      unique case (cfg.op)
         OP_PROD: entry_data.acc = Q88_ONE;
         OP_MAX:  entry_data.acc = Q88_MIN;
         default: entry_data.acc = '0;
      endcase
   end

   assign stage_valid[0] = req_chan.valid;
   assign stage_data[0]  = entry_data;
   assign req_chan.ready = stage_ready[0];

   // one stage per lane, lanes folded in order
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      eps_lane_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .lane_idx  (LANE_W'(k)),
         .cfg       (cfg),
         .in_valid  (stage_valid[k]),
         .in_ready  (stage_ready[k]),
         .in_data   (stage_data[k]),
         .out_valid (stage_valid[k+1]),
         .out_ready (stage_ready[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   // rounding of the sum and the response register
   eps_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (stage_valid[NUM_LANES]),
      .in_ready (stage_ready[NUM_LANES]),
      .in_data  (stage_data[NUM_LANES]),
      .rsp      (rsp_chan)
   );

   // a response register with nothing in it never back-pressures the requests
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("request side stalled with an empty response register");

   // a response only appears when the last lane stage held a transfer
   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(stage_valid[NUM_LANES]))
      else $error("response raised without a transfer from the lane stages");

   // reset leaves the response side empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid straight after reset");

endmodule

@@ bench/eps_result_checker.sv @@
// ----------------------------------------------------------------------------
// eps_result_checker
// watches the element and result channels and the register port, works out
// the combined element for every accepted request and compares it with the
// response that comes back, in order
// ----------------------------------------------------------------------------
module eps_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   eps_req_if                             req_mon,
   eps_rsp_if                             rsp_mon,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [eps_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [eps_pkg::CSR_DATA_W-1:0] pwdata,
   output int unsigned                    mismatches,
   output int unsigned                    outstanding
);
   import eps_pkg::*;

   typedef struct packed {
      q88_type result;
      logic    saturated;
   } combined_type;

   // mirror of the block's registers, follows every register write
   logic [OP_W-1:0] op_mirror;
   count_type       count_mirror;
   weight_type      weight_mirror [NUM_LANES];

   combined_type    expected_results [$];
   int unsigned     mismatch_count = 0;

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatch_count++;
      $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
   endtask

   function automatic longint clip_q88(input longint v, inout logic clipped);
      if (v > longint'(Q88_MAX)) begin
         clipped = 1'b1;
         return longint'(Q88_MAX);
      end
      if (v < longint'(Q88_MIN)) begin
         clipped = 1'b1;
         return longint'(Q88_MIN);
      end
      return v;
   endfunction

   function automatic combined_type combine_elems(input q88_type elem [NUM_LANES]);
      combined_type c;
      longint       acc;
      longint       total;
      logic         clipped;
      int           n;
      int           i;
      clipped = 1'b0;
      total   = 0;
      n = (count_mirror > MAX_COUNT) ? MAX_INPUTS : int'(count_mirror);
      case (op_mirror)
         OP_PROD: begin
            // round to nearest after every multiply, ties upwards
            acc = longint'(Q88_ONE);
            for (i = 0; i < n; i++)
               acc = clip_q88((acc * longint'(elem[i]) + 128) >>> 8, clipped);
         end
         OP_SUM: begin
            // exact q.20 total, rounded once
            for (i = 0; i < n; i++)
               total += longint'(elem[i]) * longint'(weight_mirror[i]);
            acc = clip_q88((total + 2048) >>> 12, clipped);
         end
         OP_MAX: begin
            acc = longint'(Q88_MIN);
            for (i = 0; i < n; i++)
               if (longint'(elem[i]) > acc)
                  acc = longint'(elem[i]);
         end
         default: acc = 0;
      endcase
      c.result    = q88_type'(acc[15:0]);
      c.saturated = clipped;
      return c;
   endfunction

   always @(posedge clock) begin
      combined_type want;
      q88_type      elems [NUM_LANES];
      int           i;
      if (reset) begin
         op_mirror    = OP_SUM;
         count_mirror = COUNT_RESET;
         for (i = 0; i < NUM_LANES; i++)
            weight_mirror[i] = WEIGHT_ONE;
         expected_results.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            elems[0] = req_mon.elem0;
            elems[1] = req_mon.elem1;
            elems[2] = req_mon.elem2;
            elems[3] = req_mon.elem3;
            expected_results.push_back(combine_elems(elems));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing outstanding", rsp_mon.result, 16'h0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.result !== want.result)
                  report_mismatch("result", rsp_mon.result, want.result);
               if (rsp_mon.saturated !== want.saturated)
                  report_mismatch("saturated", 16'(rsp_mon.saturated), 16'(want.saturated));
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_OPERATION: op_mirror        = pwdata[OP_W-1:0];
               REG_COUNT:     count_mirror     = pwdata[COUNT_W-1:0];
               REG_WEIGHT0:   weight_mirror[0] = pwdata[15:0];
               REG_WEIGHT1:   weight_mirror[1] = pwdata[15:0];
               REG_WEIGHT2:   weight_mirror[2] = pwdata[15:0];
               REG_WEIGHT3:   weight_mirror[3] = pwdata[15:0];
               default: ;
            endcase
         end
      end
      outstanding <= expected_results.size();
      mismatches  <= mismatch_count;
   end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// drives the element-wise combiner through directed corner cases and a long
// randomised run over many register settings, with random idling on both
// channels; the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb;
   import eps_pkg::*;

   // pipeline depth: one register per lane stage plus the response register
   localparam int LATENCY     = 5;
   // cycles without any transfer before the run is declared hung
   localparam int STALL_LIMIT = 1000;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 125;
   // operation code the block does not define, gives a zero result
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int unsigned mismatches;
   int unsigned outstanding;
   int          idle_cycles = 0;

   // idling switches, flipped in stretches by the stimulus
   bit idle_req = 1'b1;
   bit idle_rsp = 1'b1;

   eps_req_if req_chan ();
   eps_rsp_if rsp_chan ();

   eltwise_prod_sum_max_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   eps_result_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   // watchdog: any transfer or register access counts as progress
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one element transfer; valid is only lowered when a gap is drawn, so a
   // back-to-back transfer never sees valid dropped and raised in one step
   task automatic send_elems(input logic [63:0] elems);
      int gap;
      gap = idle_req ? $urandom_range(0, 12) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.elem0 <= elems[15:0];
      req_chan.elem1 <= elems[31:16];
      req_chan.elem2 <= elems[47:32];
      req_chan.elem3 <= elems[63:48];
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // stop sending, wait for every outstanding result, then let the pipe empty
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // apb write: setup cycle, access cycle, register taken when pready is seen
   task automatic write_reg(input reg_idx_type idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // only ever called with the block drained
   task automatic load_config(input logic [OP_W-1:0] op, input count_type count,
                              input logic [63:0] weights);
      settle();
      write_reg(REG_OPERATION, 32'(op));
      write_reg(REG_COUNT, 32'(count));
      write_reg(REG_WEIGHT0, 32'(weights[15:0]));
      write_reg(REG_WEIGHT1, 32'(weights[31:16]));
      write_reg(REG_WEIGHT2, 32'(weights[47:32]));
      write_reg(REG_WEIGHT3, 32'(weights[63:48]));
   endtask

   // mix of full-range values, values near 1.0 so products survive a few
   // steps without clipping, and the corner values
   function automatic logic [15:0] rand_elem();
      logic [15:0] corners [7];
      corners = '{16'h7fff, 16'h8000, 16'h0000, 16'h0100, 16'hff00, 16'h0001, 16'hffff};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'($urandom);
         4, 5, 6, 7: return 16'(int'($urandom_range(0, 1024)) - 512);
         default:    return corners[$urandom_range(0, 6)];
      endcase
   endfunction

   function automatic logic [15:0] rand_weight(input int phase);
      if (phase % 4 == 0)
         return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      if (phase == 1)
         return WEIGHT_ONE;
      return 16'($urandom);
   endfunction

   // response side: a fresh stall per transfer, ready held until it happens
   initial begin
      int stall;
      wait (reset === 1'b0);
      forever begin
         stall = idle_rsp ? $urandom_range(0, 12) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin
      op_type      op_cycle [3];
      logic [63:0] weights;
      int          phase;
      int          k;
      int          lane;

      op_cycle       = '{OP_PROD, OP_SUM, OP_MAX};
      req_chan.valid = 1'b0;
      req_chan.elem0 = '0;
      req_chan.elem1 = '0;
      req_chan.elem2 = '0;
      req_chan.elem3 = '0;
      rsp_chan.ready = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part ---------------------------------------------------
      // reset settings: weighted sum of two lanes at unit weight
      send_elems({16'h0000, 16'h0000, 16'h0000, 16'h0000});
      send_elems({16'h0000, 16'h0000, 16'h7fff, 16'h7fff});   // clips high
      send_elems({16'h0000, 16'h0000, 16'h8000, 16'h8000});   // clips low
      send_elems({16'h1234, 16'h5678, 16'h0001, 16'hffff});   // upper lanes ignored

      // product over all four lanes
      load_config(OP_PROD, 3'd4, {4{WEIGHT_ONE}});
      send_elems({16'h0100, 16'h0100, 16'h0100, 16'h0100});
      send_elems({16'h0100, 16'h0100, 16'h7fff, 16'h7fff});
      send_elems({16'h0100, 16'h7fff, 16'h7fff, 16'h8000});
      // half-lsb ties: 1 * 0.5 rounds up, then 1 * -0.5 rounds to zero
      send_elems({16'h7fff, 16'hff80, 16'h0080, 16'h0001});
      // clip on an early step, then multiplied back into range
      send_elems({16'h0100, 16'h0000, 16'h7fff, 16'h7fff});

      // maximum, never clips
      load_config(OP_MAX, 3'd4, {4{WEIGHT_ONE}});
      send_elems({16'h8000, 16'h8000, 16'h8000, 16'h8000});
      send_elems({16'h0000, 16'h7fff, 16'hfffd, 16'h0005});

      // weighted sum with extreme and half weights
      load_config(OP_SUM, 3'd4, {16'hffff, 16'h0800, 16'h7fff, 16'h8000});
      send_elems({16'h8000, 16'h8000, 16'h8000, 16'h8000});
      send_elems({16'hffff, 16'h0001, 16'h7fff, 16'h8000});
      send_elems({16'h0000, 16'h0001, 16'h0000, 16'h0000});   // tie rounds up
      send_elems({16'h0000, 16'hffff, 16'h0000, 16'h0000});   // tie rounds to zero

      // no lanes combined: neutral value of each operation
      load_config(OP_SUM, 3'd0, {4{WEIGHT_ONE}});
      send_elems({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
      load_config(OP_PROD, 3'd0, {4{WEIGHT_ONE}});
      send_elems({16'h8000, 16'h8000, 16'h8000, 16'h8000});
      load_config(OP_MAX, 3'd0, {4{WEIGHT_ONE}});
      send_elems({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});

      // count beyond the lane limit is clamped
      load_config(OP_SUM, 3'd7, {4{WEIGHT_ONE}});
      send_elems({16'h1000, 16'h0100, 16'h0010, 16'h0001});

      // undefined operation code
      load_config(OP_UNUSED, 3'd4, {4{WEIGHT_ONE}});
      send_elems({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});

      // --- random part -----------------------------------------------------
      // operation and count step through every pairing across the phases
      for (phase = 0; phase < PHASES; phase++) begin
         for (lane = 0; lane < NUM_LANES; lane++)
            weights[lane*16 +: 16] = rand_weight(phase);
         load_config(op_cycle[phase % 3], count_type'(1 + phase % 4), weights);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            // new idling stretch every 25 transfers, some with no gaps at all
            if (k % 25 == 0) begin
               idle_req = $urandom_range(0, 3) != 0;
               idle_rsp = $urandom_range(0, 3) != 0;
            end
            // sender holds off until the pipe has drained, mid-phase
            if (k == 60 && phase % 2 == 1)
               settle();
            send_elems({rand_elem(), rand_elem(), rand_elem(), rand_elem()});
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ eltwise_prod_sum_max_unit.f @@
rtl/eps_pkg.sv
rtl/eps_ifs.sv
rtl/eps_csr.sv
rtl/eps_lane_stage.sv
rtl/eps_out_stage.sv
rtl/eltwise_prod_sum_max_unit.sv
bench/eps_result_checker.sv
bench/tb.sv
